// ===== design/huffman_bit_packer_unit_defines.svh =====
// Shared assertion macros for the bit packer blocks.
// Each macro expects clk and rst in scope.
`ifndef HUFFMAN_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_BIT_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define HBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define HBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/hbp_pkg.sv =====
`default_nettype none
package hbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int NUM_SYMBOLS_DEF  = 256;

  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int CNTB_W = 4;
  localparam int REM_W  = 3;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } table_entry_t;

  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } q_entry_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage
`default_nettype wire

// ===== design/hbp_item_if.sv =====
`default_nettype none
interface hbp_item_if;
  logic                      valid;
  logic                      ready;
  logic [hbp_pkg::OP_W-1:0]   op;
  logic [hbp_pkg::SYM_W-1:0]  symbol;
  logic [hbp_pkg::CODE_W-1:0] code_bits;
  logic [hbp_pkg::LEN_W-1:0]  code_len;

  modport source (output valid, op, symbol, code_bits, code_len, input ready);
  modport sink (input valid, op, symbol, code_bits, code_len, output ready);
endinterface
`default_nettype wire

// ===== design/hbp_byte_if.sv =====
`default_nettype none
interface hbp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [hbp_pkg::BYTE_W-1:0] out_byte;
  logic                      last_of_run;
  logic                      is_final;
  logic [hbp_pkg::REM_W-1:0]  final_remainder;

  modport source (output valid, out_byte, last_of_run, is_final, final_remainder,
                  input ready);
  modport sink (input valid, out_byte, last_of_run, is_final, final_remainder,
                output ready);
endinterface
`default_nettype wire

// ===== design/hbp_front.sv =====
`default_nettype none
module hbp_front #(
  parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
  parameter int NUM_SYMBOLS  = hbp_pkg::NUM_SYMBOLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  hbp_item_if.sink           items,
  input  hbp_pkg::q_status_t q_status,
  output logic               push,
  output hbp_pkg::q_entry_t  push_entry
);
  import hbp_pkg::*;

  localparam int IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int CAP   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  table_entry_t           code_table [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] entry_valid;
  table_entry_t           rd_entry;
  logic                   rd_valid;
  logic                   s1_valid;
  logic                   s1_flush;

  logic              accept;
  logic              in_range;
  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  len_sat;
  logic              do_load;
  logic              do_queue;
  table_entry_t      wr_entry;

  assign accept   = items.valid && items.ready;
  assign in_range = {1'b0, items.symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
  assign idx      = items.symbol[IDX_W-1:0];
  assign len_sat  = (items.code_len > LEN_W'(CAP)) ? LEN_W'(CAP) : items.code_len;
  assign wr_entry.len  = len_sat;
  assign wr_entry.code = items.code_bits & ~({CODE_W{1'b1}} << len_sat);

  assign items.ready = !rst &&
                       ((q_status.count + QCNT_W'(s1_valid)) < QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    do_load  = 1'b0;
    do_queue = 1'b0;
    unique case (items.op)
      OP_LOAD:   do_load  = accept && in_range;
      OP_ENCODE: do_queue = accept && in_range;
      OP_FLUSH:  do_queue = accept;
      default: begin
        do_load  = 1'b0;
        do_queue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_table[idx] <= wr_entry;
    end
    rd_entry <= code_table[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
      s1_valid    <= 1'b0;
      s1_flush    <= 1'b0;
    end else begin
      if (do_load) begin
        entry_valid[idx] <= 1'b1;
      end
      rd_valid <= entry_valid[idx];
      s1_valid <= do_queue;
      s1_flush <= (items.op == OP_FLUSH);
    end
  end

  assign push             = s1_valid;
  assign push_entry.flush = s1_flush;
  assign push_entry.code  = rd_entry.code;
  assign push_entry.len   = rd_valid ? rd_entry.len : '0;

endmodule
`default_nettype wire

// ===== design/hbp_queue.sv =====
`default_nettype none
`include "huffman_bit_packer_unit_defines.svh"
module hbp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hbp_pkg::q_entry_t  push_entry,
  input  logic               pop,
  output hbp_pkg::q_entry_t  head,
  output hbp_pkg::q_status_t status
);
  import hbp_pkg::*;

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.count = count;

  `HBP_ASSERT_IMP(a_no_overflow, push && !pop, count < QCNT_W'(QUEUE_DEPTH))
  `HBP_ASSERT_IMP(a_no_underflow, pop, count != '0)
  `HBP_ASSERT_IMP(a_count_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))

endmodule
`default_nettype wire

// ===== design/hbp_back.sv =====
`default_nettype none
`include "huffman_bit_packer_unit_defines.svh"
module hbp_back (
  input  logic               clk,
  input  logic               rst,
  input  hbp_pkg::q_entry_t  head,
  input  hbp_pkg::q_status_t q_status,
  output logic               pop,
  hbp_byte_if.source         packed_bytes
);
  import hbp_pkg::*;

  logic              busy;
  logic              is_flush;
  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  remain;
  logic [BYTE_W-1:0] pending_bits;
  logic [CNTB_W-1:0] pending_count;

  logic              busy_next;
  logic              is_flush_next;
  logic [CODE_W-1:0] code_next;
  logic [LEN_W-1:0]  remain_next;
  logic [BYTE_W-1:0] pending_bits_next;
  logic [CNTB_W-1:0] pending_count_next;

  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic              emit_final;
  logic [REM_W-1:0]  emit_rem;

  logic              out_free;
  logic [CNTB_W-1:0] avail;
  logic [CNTB_W-1:0] take;
  logic [BYTE_W+CODE_W-1:0] merged;

  assign out_free = !packed_bytes.valid || packed_bytes.ready;
  assign avail    = CNTB_W'(BYTE_W) - pending_count;
  assign take     = (remain < {{(LEN_W-CNTB_W){1'b0}}, avail}) ? remain[CNTB_W-1:0] : avail;
  assign merged   = {pending_bits, code} << take;

  always_comb begin
    busy_next          = busy;
    is_flush_next      = is_flush;
    code_next          = code;
    remain_next        = remain;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    pop                = 1'b0;
    emit               = 1'b0;
    emit_byte          = pending_bits;
    emit_last          = 1'b0;
    emit_final         = 1'b0;
    emit_rem           = '0;
    priority if (!busy) begin
      if (!q_status.empty) begin
        pop           = 1'b1;
        is_flush_next = head.flush;
        remain_next   = head.len;
        code_next     = head.code << (LEN_W'(CODE_W) - head.len);
        busy_next     = head.flush || (head.len != '0);
      end
    end else if (is_flush) begin
      if (out_free) begin
        emit               = 1'b1;
        emit_last          = 1'b1;
        emit_final         = 1'b1;
        emit_rem           = pending_count[REM_W-1:0];
        pending_bits_next  = '0;
        pending_count_next = '0;
        busy_next          = 1'b0;
      end
    end else if (pending_count == CNTB_W'(BYTE_W)) begin
      if (out_free) begin
        emit               = 1'b1;
        emit_last          = (remain <= LEN_W'(BYTE_W));
        pending_bits_next  = '0;
        pending_count_next = '0;
      end
    end else begin
      pending_bits_next  = merged[BYTE_W+CODE_W-1:CODE_W];
      code_next          = merged[CODE_W-1:0];
      pending_count_next = pending_count + take;
      remain_next        = remain - {{(LEN_W-CNTB_W){1'b0}}, take};
      busy_next          = (remain_next != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      is_flush      <= 1'b0;
      remain        <= '0;
      pending_bits  <= '0;
      pending_count <= '0;
      packed_bytes.valid <= 1'b0;
    end else begin
      busy          <= busy_next;
      is_flush      <= is_flush_next;
      remain        <= remain_next;
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      if (emit) begin
        packed_bytes.valid <= 1'b1;
      end else if (packed_bytes.ready) begin
        packed_bytes.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    code <= code_next;
    if (emit) begin
      packed_bytes.out_byte        <= emit_byte;
      packed_bytes.last_of_run     <= emit_last;
      packed_bytes.is_final        <= emit_final;
      packed_bytes.final_remainder <= emit_rem;
    end
  end

  `HBP_ASSERT_IMP(a_pending_bound, 1'b1, pending_count <= CNTB_W'(BYTE_W))
  `HBP_ASSERT_IMP(a_emit_full, emit && !emit_final, pending_count == CNTB_W'(BYTE_W))
  `HBP_ASSERT_IMP(a_encode_live, busy && !is_flush,
                  remain != '0 && remain <= LEN_W'(CODE_W))
  `HBP_ASSERT_NXT(a_flush_clears, emit && emit_final, pending_count == '0)

endmodule
`default_nettype wire

// ===== design/huffman_bit_packer_unit.sv =====
// Channel       Dir  Payload
// items         in   op, symbol, code_bits, code_len
// packed_bytes  out  out_byte, last_of_run, is_final, final_remainder
//
// Load items write the table at transfer; encode and flush items queue after one table read.
// The packer moves up to 8 code bits per cycle while the pending byte has room: an encode is
// popped, shifted into the pending byte in parts (one more part when a part-full pending byte
// splits the code) and each full byte is sent; a flush is popped, then sends the final byte.
// Reset clears the table's valid bits, the queue and the pending byte at once.
// A stalled output holds the packer; the queue (4 deep) then fills and drops ready.
`default_nettype none
module huffman_bit_packer_unit #(
  parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
  parameter int NUM_SYMBOLS  = hbp_pkg::NUM_SYMBOLS_DEF
) (
  input logic        clk,
  input logic        rst,
  hbp_item_if.sink   items,
  hbp_byte_if.source packed_bytes
);
  import hbp_pkg::*;

  logic      push;
  q_entry_t  push_entry;
  logic      pop;
  q_entry_t  head;
  q_status_t q_status;

  hbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  hbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  hbp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .packed_bytes (packed_bytes)
  );

endmodule
`default_nettype wire
